// ===== design/rct_pkg.sv =====
// types and constants shared by the retransmit connection table
// no dependencies
`timescale 1ns / 1ps

package rct_pkg;

  typedef enum logic [1:0] {
    ACT_OPEN     = 2'd0,
    ACT_REQUEST  = 2'd1,
    ACT_RESPONSE = 2'd2,
    ACT_TICK     = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    RES_OPENED  = 3'd0,
    RES_RESEND  = 3'd1,
    RES_TIMEOUT = 3'd2,
    RES_EXECUTE = 3'd3,
    RES_REPLY   = 3'd4,
    RES_DELIVER = 3'd5,
    RES_STATUS  = 3'd6
  } result_e;

  typedef enum logic [1:0] {
    EK_EMPTY   = 2'd0,
    EK_SEND    = 2'd1,
    EK_RECEIVE = 2'd2
  } entry_kind_e;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_OPEN  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_EV    = 7'b0001000,
    S_RES   = 7'b0010000,
    S_REPLY = 7'b0100000,
    S_STAT  = 7'b1000000
  } state_e;

  localparam logic CFG_WAIT_TICKS   = 1'b0;
  localparam logic CFG_RESEND_LIMIT = 1'b1;

  typedef struct packed {
    logic [15:0] address;
    logic [7:0]  device;
    logic [7:0]  id;
    logic [7:0]  command;
    logic [7:0]  arg_one;
    logic [7:0]  arg_two;
  } msg_t;

  typedef struct packed {
    entry_kind_e kind;
    msg_t        msg;
    logic [7:0]  wait_left;
    logic [7:0]  resends_left;
  } entry_t;

  typedef struct packed {
    result_e    kind;
    logic [2:0] slot;
    msg_t       msg;
    logic       timer_running;
    logic       last;
  } out_t;

  function automatic out_t make_out(result_e k, logic [2:0] s, msg_t m, logic t, logic l);
    out_t o;
    o.kind          = k;
    o.slot          = s;
    o.msg           = m;
    o.timer_running = t;
    o.last          = l;
    return o;
  endfunction

endpackage

// ===== design/rct_in_if.sv =====
// input channel of the retransmit connection table
// depends on nothing
`timescale 1ns / 1ps

interface rct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] peer_address;
  logic [7:0]  node_device;
  logic [7:0]  msg_id;
  logic [7:0]  command;
  logic [7:0]  arg_one;
  logic [7:0]  arg_two;

  modport source (output valid, action, peer_address, node_device, msg_id, command,
                  arg_one, arg_two, input ready);
  modport sink (input valid, action, peer_address, node_device, msg_id, command,
                arg_one, arg_two, output ready);
endinterface

// ===== design/rct_out_if.sv =====
// result channel of the retransmit connection table
// depends on nothing
`timescale 1ns / 1ps

interface rct_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [2:0]  slot;
  logic [15:0] out_address;
  logic [7:0]  out_device;
  logic [7:0]  out_id;
  logic [7:0]  out_command;
  logic [7:0]  out_arg_one;
  logic [7:0]  out_arg_two;
  logic        timer_running;
  logic        last;

  modport source (output valid, kind, slot, out_address, out_device, out_id, out_command,
                  out_arg_one, out_arg_two, timer_running, last, input ready);
  modport sink (input valid, kind, slot, out_address, out_device, out_id, out_command,
                out_arg_one, out_arg_two, timer_running, last, output ready);
endinterface

// ===== design/retransmit_connection_table_unit.sv =====
// retransmit connection table: entries in one synchronous memory, scanned one slot at a time
// depends on rct_pkg, rct_in_if, rct_out_if
// open send writes the next slot directly; request and response scan the keys serially;
// tick reads each slot then updates it if it is a send entry; a step that pushes a result waits on result stalls
// one item at a time; the next transfer is taken after the status result is registered
// reset clears control state and per-slot valid bits; an entry not yet written reads as zero
`timescale 1ns / 1ps

module retransmit_connection_table_unit import rct_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  rct_in_if.sink     in_ch,
  rct_out_if.source  out_ch
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] LastIdx = SW'(SLOTS - 1);

  state_e          state_q, state_d;
  action_e         act_q;
  msg_t            msg_q;
  logic [SW-1:0]   idx_q, idx_d;
  logic [SW-1:0]   ptr_q, ptr_d, ptr_next;
  logic            found_q, found_d;
  logic            timer_q, timer_d;
  logic [SLOTS-1:0] live_q, live_d;
  logic [SLOTS-1:0] valid_q, valid_d;
  logic [7:0]      wait_ticks_q, resend_limit_q;
  entry_t          mem_q [SLOTS];
  entry_t          rdata_q;
  logic            rvalid_q;
  entry_t          cur;
  logic            re;
  logic            we;
  logic [SW-1:0]   waddr;
  entry_t          wdata;
  logic            push;
  out_t            push_res;
  out_t            out_q;
  logic            out_valid_q;
  logic            can_push;
  logic            idx_last;
  logic            match;
  logic [SW+2:0]   idx_ext, ptr_ext;
  logic [7:0]      wait_dec, res_dec;

  assign in_ch.ready = (state_q == S_IDLE);
  assign can_push    = !out_valid_q || out_ch.ready;
  assign ptr_next    = (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;
  assign idx_last    = (idx_q == LastIdx);
  assign cur         = rvalid_q ? rdata_q : '0;
  assign match       = (cur.msg.id == msg_q.id) && (cur.msg.address == msg_q.address);
  assign idx_ext     = {3'b000, idx_q};
  assign ptr_ext     = {3'b000, ptr_next};
  assign wait_dec    = cur.wait_left - 8'd1;
  assign res_dec     = cur.resends_left - 8'd1;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    ptr_d    = ptr_q;
    found_d  = found_q;
    timer_d  = timer_q;
    live_d   = live_q;
    valid_d  = valid_q;
    re       = 1'b0;
    we       = 1'b0;
    waddr    = idx_q;
    wdata    = cur;
    push     = 1'b0;
    push_res = make_out(RES_STATUS, 3'd0, '0, timer_q, 1'b0);
    unique case (state_q)
      S_IDLE: begin
        if (in_ch.valid) begin
          idx_d   = '0;
          found_d = 1'b0;
          unique case (action_e'(in_ch.action))
            ACT_OPEN: state_d = S_OPEN;
            ACT_TICK: begin
              timer_d = |live_q;
              state_d = S_RD;
            end
            default: state_d = S_RD;
          endcase
        end
      end
      S_OPEN: begin
        if (can_push) begin
          we                = 1'b1;
          waddr             = ptr_next;
          wdata.kind        = EK_SEND;
          wdata.msg         = msg_q;
          wdata.wait_left   = wait_ticks_q;
          wdata.resends_left = resend_limit_q;
          valid_d[ptr_next] = 1'b1;
          live_d[ptr_next]  = (wait_ticks_q != 8'd0) || (resend_limit_q != 8'd0);
          ptr_d             = ptr_next;
          timer_d           = 1'b1;
          push              = 1'b1;
          push_res          = make_out(RES_OPENED, ptr_ext[2:0], msg_q, 1'b1, 1'b0);
          state_d           = S_STAT;
        end
      end
      S_RD: begin
        re      = 1'b1;
        state_d = S_EV;
      end
      S_EV: begin
        if (act_q == ACT_TICK) begin
          priority if (cur.kind != EK_SEND) begin
            state_d = idx_last ? S_STAT : S_RD;
            idx_d   = idx_last ? idx_q : idx_q + 1'b1;
          end else if (cur.wait_left != 8'd0) begin
            we              = 1'b1;
            wdata.wait_left = wait_dec;
            live_d[idx_q]   = (wait_dec != 8'd0) || (cur.resends_left != 8'd0);
            state_d         = idx_last ? S_STAT : S_RD;
            idx_d           = idx_last ? idx_q : idx_q + 1'b1;
          end else begin
            if (can_push) begin
              we   = 1'b1;
              push = 1'b1;
              if (cur.resends_left != 8'd0) begin
                wdata.resends_left = res_dec;
                wdata.wait_left    = wait_ticks_q;
                live_d[idx_q]      = (res_dec != 8'd0) || (wait_ticks_q != 8'd0);
                push_res = make_out(RES_RESEND, idx_ext[2:0], cur.msg, timer_q, 1'b0);
              end else begin
                wdata.kind    = EK_EMPTY;
                live_d[idx_q] = 1'b0;
                push_res = make_out(RES_TIMEOUT, idx_ext[2:0], cur.msg, timer_q, 1'b0);
              end
              state_d = idx_last ? S_STAT : S_RD;
              idx_d   = idx_last ? idx_q : idx_q + 1'b1;
            end
          end
        end else begin
          priority if (match) begin
            found_d = 1'b1;
            state_d = S_RES;
          end else if (idx_last) begin
            state_d = S_RES;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_RD;
          end
        end
      end
      S_RES: begin
        if (act_q == ACT_REQUEST) begin
          priority if (found_q) begin
            state_d = (cur.kind == EK_RECEIVE) ? S_REPLY : S_STAT;
          end else begin
            if (can_push) begin
              we                 = 1'b1;
              waddr              = ptr_next;
              wdata.kind         = EK_RECEIVE;
              wdata.msg          = msg_q;
              wdata.wait_left    = 8'd0;
              wdata.resends_left = 8'd0;
              valid_d[ptr_next]  = 1'b1;
              live_d[ptr_next]   = 1'b0;
              ptr_d              = ptr_next;
              idx_d              = ptr_next;
              timer_d            = 1'b1;
              push               = 1'b1;
              push_res = make_out(RES_EXECUTE, ptr_ext[2:0], msg_q, 1'b1, 1'b0);
              state_d            = S_REPLY;
            end
          end
        end else begin
          priority if (!found_q) begin
            state_d = S_STAT;
          end else begin
            if (can_push) begin
              we             = 1'b1;
              wdata.kind     = EK_EMPTY;
              valid_d[idx_q] = 1'b1;
              live_d[idx_q]  = 1'b0;
              push           = 1'b1;
              push_res = make_out(RES_DELIVER, idx_ext[2:0], msg_q, timer_q, 1'b0);
              state_d        = S_STAT;
            end
          end
        end
      end
      S_REPLY: begin
        if (can_push) begin
          push     = 1'b1;
          push_res = make_out(RES_REPLY, idx_ext[2:0], msg_q, timer_q, 1'b0);
          state_d  = S_STAT;
        end
      end
      S_STAT: begin
        if (can_push) begin
          push     = 1'b1;
          push_res = make_out(RES_STATUS, 3'd0, '0, timer_q, 1'b1);
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      idx_q          <= '0;
      ptr_q          <= '0;
      found_q        <= 1'b0;
      timer_q        <= 1'b0;
      live_q         <= '0;
      valid_q        <= '0;
      rvalid_q       <= 1'b0;
      out_valid_q    <= 1'b0;
      wait_ticks_q   <= 8'd10;
      resend_limit_q <= 8'd3;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ptr_q   <= ptr_d;
      found_q <= found_d;
      timer_q <= timer_d;
      live_q  <= live_d;
      valid_q <= valid_d;
      if (re) begin
        rvalid_q <= valid_q[idx_q];
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WAIT_TICKS:   wait_ticks_q   <= cfg_data_i;
          CFG_RESEND_LIMIT: resend_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // input latch and result register
  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      act_q         <= action_e'(in_ch.action);
      msg_q.address <= in_ch.peer_address;
      msg_q.device  <= in_ch.node_device;
      msg_q.id      <= in_ch.msg_id;
      msg_q.command <= in_ch.command;
      msg_q.arg_one <= in_ch.arg_one;
      msg_q.arg_two <= in_ch.arg_two;
    end
    if (push) begin
      out_q <= push_res;
    end
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[idx_q];
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.kind          = out_q.kind;
  assign out_ch.slot          = out_q.slot;
  assign out_ch.out_address   = out_q.msg.address;
  assign out_ch.out_device    = out_q.msg.device;
  assign out_ch.out_id        = out_q.msg.id;
  assign out_ch.out_command   = out_q.msg.command;
  assign out_ch.out_arg_one   = out_q.msg.arg_one;
  assign out_ch.out_arg_two   = out_q.msg.arg_two;
  assign out_ch.timer_running = out_q.timer_running;
  assign out_ch.last          = out_q.last;

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench of the retransmit connection table unit
// depends on rct_pkg, rct_in_if, rct_out_if and the table unit itself
`timescale 1ns / 1ps

module tb;
  import rct_pkg::*;

  localparam int NSLOT = 8;

  typedef struct packed {
    result_e    kind;
    logic [2:0] slot;
    msg_t       msg;
    logic       timer_running;
    logic       last;
  } res_t;

  class table_scoreboard;
    entry_kind_e kinds[NSLOT];
    msg_t        msgs[NSLOT];
    logic [7:0]  wait_cnt[NSLOT];
    logic [7:0]  resend_cnt[NSLOT];
    logic [2:0]  alloc_ptr;
    logic        timer_on;
    logic [7:0]  wait_ticks;
    logic [7:0]  resend_limit;
    res_t        pending_q[$];
    int          errors;
    int          checked;

    function new();
      foreach (kinds[i]) begin
        kinds[i] = EK_EMPTY;
        msgs[i] = '0;
        wait_cnt[i] = '0;
        resend_cnt[i] = '0;
      end
      alloc_ptr = '0;
      timer_on = 1'b0;
      wait_ticks = 8'd10;
      resend_limit = 8'd3;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic idx, logic [7:0] val);
      if (idx == CFG_WAIT_TICKS) wait_ticks = val;
      else resend_limit = val;
    endfunction

    function int lookup(msg_t m);
      for (int i = 0; i < NSLOT; i++)
        if (msgs[i].id == m.id && msgs[i].address == m.address) return i;
      return -1;
    endfunction

    function logic [2:0] alloc(entry_kind_e k, msg_t m);
      logic [2:0] s;
      s = alloc_ptr + 3'd1;
      alloc_ptr = s;
      kinds[s] = k;
      msgs[s] = m;
      wait_cnt[s] = (k == EK_SEND) ? wait_ticks : 8'd0;
      resend_cnt[s] = (k == EK_SEND) ? resend_limit : 8'd0;
      timer_on = 1'b1;
      return s;
    endfunction

    function void note_input(action_e act, msg_t m);
      res_t batch[$];
      res_t r;
      int f;
      int active;
      logic [2:0] s;
      r = '0;
      case (act)
        ACT_OPEN: begin
          s = alloc(EK_SEND, m);
          r.kind = RES_OPENED; r.slot = s; r.msg = m; batch.push_back(r);
        end
        ACT_REQUEST: begin
          f = lookup(m);
          if (f < 0) begin
            s = alloc(EK_RECEIVE, m);
            r.kind = RES_EXECUTE; r.slot = s; r.msg = m; batch.push_back(r);
          end else s = f[2:0];
          if (kinds[s] == EK_RECEIVE) begin
            r.kind = RES_REPLY; r.slot = s; r.msg = m; batch.push_back(r);
          end
        end
        ACT_RESPONSE: begin
          f = lookup(m);
          if (f >= 0) begin
            kinds[f] = EK_EMPTY;
            r.kind = RES_DELIVER; r.slot = f[2:0]; r.msg = m; batch.push_back(r);
          end
        end
        default: begin
          active = 0;
          for (int i = 0; i < NSLOT; i++) begin
            if (kinds[i] != EK_SEND) continue;
            r.slot = i[2:0]; r.msg = msgs[i];
            if (wait_cnt[i] != 0) begin
              wait_cnt[i]--; active++;
            end else if (resend_cnt[i] != 0) begin
              r.kind = RES_RESEND; batch.push_back(r);
              resend_cnt[i]--; wait_cnt[i] = wait_ticks; active++;
            end else begin
              kinds[i] = EK_EMPTY;
              r.kind = RES_TIMEOUT; batch.push_back(r);
            end
          end
          if (active == 0) timer_on = 1'b0;
        end
      endcase
      r = '0;
      r.kind = RES_STATUS; r.last = 1'b1;
      batch.push_back(r);
      foreach (batch[i]) begin
        batch[i].timer_running = timer_on;
        pending_q.push_back(batch[i]);
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      checked++;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: kind %0d slot %0d", got.kind, got.slot);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.kind !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, got.kind); errors++;
      end
      if (got.slot !== e.slot) begin
        $error("slot: expected %0d, got %0d", e.slot, got.slot); errors++;
      end
      if (got.msg.address !== e.msg.address) begin
        $error("out_address: expected %h, got %h", e.msg.address, got.msg.address); errors++;
      end
      if (got.msg.device !== e.msg.device) begin
        $error("out_device: expected %h, got %h", e.msg.device, got.msg.device); errors++;
      end
      if (got.msg.id !== e.msg.id) begin
        $error("out_id: expected %h, got %h", e.msg.id, got.msg.id); errors++;
      end
      if (got.msg.command !== e.msg.command) begin
        $error("out_command: expected %h, got %h", e.msg.command, got.msg.command); errors++;
      end
      if (got.msg.arg_one !== e.msg.arg_one) begin
        $error("out_arg_one: expected %h, got %h", e.msg.arg_one, got.msg.arg_one); errors++;
      end
      if (got.msg.arg_two !== e.msg.arg_two) begin
        $error("out_arg_two: expected %h, got %h", e.msg.arg_two, got.msg.arg_two); errors++;
      end
      if (got.timer_running !== e.timer_running) begin
        $error("timer_running: expected %b, got %b", e.timer_running, got.timer_running);
        errors++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %b, got %b", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [7:0] cfg_data_i;

  rct_in_if  in_ch ();
  rct_out_if out_ch ();

  retransmit_connection_table_unit #(.SLOTS(NSLOT)) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  table_scoreboard sb;
  bit     quiet;
  int     cycles;
  int     sent;
  int     act_count[4];
  msg_t   recent[$];
  localparam int LIMIT = 600000;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: check at rising edge, stall bursts at falling edge
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready)
        sb.check_result({result_e'(out_ch.kind), out_ch.slot,
                         {out_ch.out_address, out_ch.out_device, out_ch.out_id,
                          out_ch.out_command, out_ch.out_arg_one, out_ch.out_arg_two},
                         out_ch.timer_running, out_ch.last});
      @(negedge clk_i);
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 18) - 1;
        out_ch.ready <= 1'b0;
      end else out_ch.ready <= 1'b1;
    end
  end

  task automatic write_reg(logic idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (2 * NSLOT + 8) @(posedge clk_i);
  endtask

  // in_ch signals are changed at falling edges only
  task automatic send_item(action_e act, msg_t m);
    if (!quiet && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 18)) @(negedge clk_i);
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    {in_ch.peer_address, in_ch.node_device, in_ch.msg_id, in_ch.command,
     in_ch.arg_one, in_ch.arg_two} <= m;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(act, m);
    sent++;
    act_count[act]++;
    if (act == ACT_OPEN || act == ACT_REQUEST) begin
      recent.push_back(m);
      if (recent.size() > 12) void'(recent.pop_front());
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
  endtask

  function automatic msg_t rand_msg();
    msg_t m;
    m.address = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3));
    m.device = 8'($urandom);
    m.id = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3));
    m.command = 8'($urandom);
    m.arg_one = 8'($urandom);
    m.arg_two = 8'($urandom);
    return m;
  endfunction

  task automatic random_phase(int n);
    action_e act;
    msg_t m;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      act = sel < 2 ? ACT_OPEN : sel < 4 ? ACT_REQUEST : sel < 6 ? ACT_RESPONSE : ACT_TICK;
      m = rand_msg();
      // mostly answer or repeat a known key so that lookups hit
      if ((act == ACT_RESPONSE || act == ACT_REQUEST) && recent.size() != 0
          && $urandom_range(0, 2) != 0) begin
        msg_t k;
        k = recent[$urandom_range(0, recent.size() - 1)];
        m.address = k.address;
        m.id = k.id;
      end
      send_item(act, m);
    end
  endtask

  initial begin
    msg_t m;
    sb = new();
    quiet = 1'b0;
    cycles = 0;
    sent = 0;
    act_count = '{default: 0};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_WAIT_TICKS; cfg_data_i = '0;
    in_ch.valid = 1'b0; in_ch.action = ACT_OPEN;
    in_ch.peer_address = '0; in_ch.node_device = '0; in_ch.msg_id = '0;
    in_ch.command = '0; in_ch.arg_one = '0; in_ch.arg_two = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: key zero matches the cleared table, extremes, every action
    send_item(ACT_TICK, '0);
    send_item(ACT_REQUEST, '0);
    send_item(ACT_RESPONSE, '0);
    send_item(ACT_RESPONSE, '0);
    send_item(ACT_OPEN, '1);
    send_item(ACT_REQUEST, '1);
    send_item(ACT_REQUEST, {16'h1234, 8'h00, 8'h55, 8'hff, 8'h00, 8'hff});
    send_item(ACT_REQUEST, {16'h1234, 8'hff, 8'h55, 8'h00, 8'hff, 8'h00});
    send_item(ACT_RESPONSE, '1);
    send_item(ACT_RESPONSE, {16'hbeef, 8'h1, 8'h2, 8'h3, 8'h4, 8'h5});
    drain();
    write_reg(CFG_WAIT_TICKS, 8'd0);
    write_reg(CFG_RESEND_LIMIT, 8'd0);
    send_item(ACT_OPEN, {16'h0001, 8'ha5, 8'h01, 8'h11, 8'h22, 8'h33});
    send_item(ACT_TICK, '0);
    drain();
    write_reg(CFG_RESEND_LIMIT, 8'd2);
    for (int i = 0; i < 9; i++) send_item(ACT_OPEN, {16'(i), 8'(i), 8'(i), 8'h0f, 8'hf0, 8'h5a});
    repeat (4) send_item(ACT_TICK, '0);
    drain();

    // random phases over several settings, the extremes among them
    write_reg(CFG_WAIT_TICKS, 8'd1);
    write_reg(CFG_RESEND_LIMIT, 8'd1);
    random_phase(80);
    drain();
    write_reg(CFG_WAIT_TICKS, 8'd255);
    write_reg(CFG_RESEND_LIMIT, 8'd255);
    random_phase(40);
    drain();
    write_reg(CFG_WAIT_TICKS, 8'd2);
    write_reg(CFG_RESEND_LIMIT, 8'd3);
    random_phase(60);
    drain();
    write_reg(CFG_WAIT_TICKS, 8'($urandom_range(0, 4)));
    write_reg(CFG_RESEND_LIMIT, 8'($urandom_range(0, 4)));
    random_phase(60);
    quiet = 1'b1;
    random_phase(45);

    drain();
    $display("%0d items sent (open %0d, request %0d, response %0d, tick %0d)",
             sent, act_count[ACT_OPEN], act_count[ACT_REQUEST], act_count[ACT_RESPONSE],
             act_count[ACT_TICK]);
    $display("%0d results checked over seven register settings", sb.checked);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/rct_pkg.sv
design/rct_in_if.sv
design/rct_out_if.sv
design/retransmit_connection_table_unit.sv
tb/sv/tb.sv
